FILE: sv/gpioc_pkg.sv
// types, register map and defaults shared by the gpio controller modules
package gpioc_pkg;

  localparam int unsigned DATA_W        = 16;
  localparam int unsigned PIN_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PINS  = 2'd2
  } act_e;

  typedef enum logic [4:0] {
    WORD_PIN_IN      = 5'd0,
    WORD_IN_ENABLE   = 5'd1,
    WORD_OUT_ENABLE  = 5'd2,
    WORD_OUT_LEVEL   = 5'd3,
    WORD_PULLUP      = 5'd4,
    WORD_DRIVE       = 5'd5,
    WORD_RISE_ENABLE = 5'd6,
    WORD_RISE_PEND   = 5'd7,
    WORD_FALL_ENABLE = 5'd8,
    WORD_FALL_PEND   = 5'd9,
    WORD_HIGH_ENABLE = 5'd10,
    WORD_HIGH_PEND   = 5'd11,
    WORD_LOW_ENABLE  = 5'd12,
    WORD_LOW_PEND    = 5'd13,
    WORD_OUT_INVERT  = 5'd16
  } reg_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [4:0]        reg_word;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_set;
    logic [DATA_W-1:0] pin_mask;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] irq_pins;
    logic [DATA_W-1:0] pin_levels;
  } out_t;

  // decoded control for one accepted transaction, shared by all lanes
  typedef struct packed {
    logic       fire;
    logic       rd;
    logic       wr;
    logic       pins;
    logic       eval;
    logic [4:0] word;
  } ctl_t;

endpackage

FILE: sv/gpioc_lane.sv
// one pin lane: register bits, pin level and interrupt detection for a single pin
module gpioc_lane import gpioc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  logic data_i,
  input  logic set_i,
  input  logic mask_i,
  output logic rd_o,
  output logic irq_o,
  output logic level_o
);

  logic level_q, level_d, ival_q, ival_d, ie_q, ie_d, oe_q, oe_d;
  logic ov_q, ov_d, inv_q, inv_d, pue_q, pue_d, ds_q, ds_d;
  logic rie_q, rie_d, fie_q, fie_d, hie_q, hie_d, lie_q, lie_d;
  logic rip_q, rip_d, fip_q, fip_d, hip_q, hip_d, lip_q, lip_d;
  logic wr, ev, level_ext, level_new, hi, lo, rise, fall;

  assign wr = ctl_i.fire & ctl_i.wr;
  assign ev = ctl_i.fire & ctl_i.eval;

  always_comb begin
    ie_d  = (wr && ctl_i.word == WORD_IN_ENABLE)   ? data_i : ie_q;
    oe_d  = (wr && ctl_i.word == WORD_OUT_ENABLE)  ? data_i : oe_q;
    ov_d  = (wr && ctl_i.word == WORD_OUT_LEVEL)   ? data_i : ov_q;
    inv_d = (wr && ctl_i.word == WORD_OUT_INVERT)  ? data_i : inv_q;
    pue_d = (wr && ctl_i.word == WORD_PULLUP)      ? data_i : pue_q;
    ds_d  = (wr && ctl_i.word == WORD_DRIVE)       ? data_i : ds_q;
    rie_d = (wr && ctl_i.word == WORD_RISE_ENABLE) ? data_i : rie_q;
    fie_d = (wr && ctl_i.word == WORD_FALL_ENABLE) ? data_i : fie_q;
    hie_d = (wr && ctl_i.word == WORD_HIGH_ENABLE) ? data_i : hie_q;
    lie_d = (wr && ctl_i.word == WORD_LOW_ENABLE)  ? data_i : lie_q;

    level_ext = (ctl_i.pins && mask_i) ? set_i : level_q;
    level_new = oe_d ? (ov_d ^ inv_d) : level_ext;

    hi   = hie_d & level_new;
    lo   = lie_d & ~level_new;
    rise = rie_d & ~level_q & level_new;
    fall = fie_d & level_q & ~level_new;

    // write one to clear, then set from the evaluation
    rip_d = (wr && ctl_i.word == WORD_RISE_PEND) ? (rip_q & ~data_i) : rip_q;
    fip_d = (wr && ctl_i.word == WORD_FALL_PEND) ? (fip_q & ~data_i) : fip_q;
    hip_d = (wr && ctl_i.word == WORD_HIGH_PEND) ? (hip_q & ~data_i) : hip_q;
    lip_d = (wr && ctl_i.word == WORD_LOW_PEND)  ? (lip_q & ~data_i) : lip_q;
    if (ev) begin
      rip_d = rip_d | rise;
      fip_d = fip_d | fall;
      hip_d = hip_d | hi;
      lip_d = lip_d | lo;
    end

    level_d = ev ? level_new : level_q;
    ival_d  = ev ? (level_new & ie_d) : ival_q;
  end

  always_comb begin
    case (ctl_i.word)
      WORD_PIN_IN:      rd_o = ival_q;
      WORD_IN_ENABLE:   rd_o = ie_q;
      WORD_OUT_ENABLE:  rd_o = oe_q;
      WORD_OUT_LEVEL:   rd_o = ov_q;
      WORD_PULLUP:      rd_o = pue_q;
      WORD_DRIVE:       rd_o = ds_q;
      WORD_RISE_ENABLE: rd_o = rie_q;
      WORD_RISE_PEND:   rd_o = rip_q;
      WORD_FALL_ENABLE: rd_o = fie_q;
      WORD_FALL_PEND:   rd_o = fip_q;
      WORD_HIGH_ENABLE: rd_o = hie_q;
      WORD_HIGH_PEND:   rd_o = hip_q;
      WORD_LOW_ENABLE:  rd_o = lie_q;
      WORD_LOW_PEND:    rd_o = lip_q;
      WORD_OUT_INVERT:  rd_o = inv_q;
      default:          rd_o = 1'b0;
    endcase
    if (!ctl_i.rd) begin
      rd_o = 1'b0;
    end
  end

  assign irq_o   = ev & (hi | lo | rise | fall);
  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0; ival_q <= 1'b0; ie_q  <= 1'b0; oe_q  <= 1'b0;
      ov_q    <= 1'b0; inv_q  <= 1'b0; pue_q <= 1'b0; ds_q  <= 1'b0;
      rie_q   <= 1'b0; fie_q  <= 1'b0; hie_q <= 1'b0; lie_q <= 1'b0;
      rip_q   <= 1'b0; fip_q  <= 1'b0; hip_q <= 1'b0; lip_q <= 1'b0;
    end else begin
      level_q <= level_d; ival_q <= ival_d; ie_q  <= ie_d;  oe_q  <= oe_d;
      ov_q    <= ov_d;    inv_q  <= inv_d;  pue_q <= pue_d; ds_q  <= ds_d;
      rie_q   <= rie_d;   fie_q  <= fie_d;  hie_q <= hie_d; lie_q <= lie_d;
      rip_q   <= rip_d;   fip_q  <= fip_d;  hip_q <= hip_d; lip_q <= lip_d;
    end
  end

endmodule

FILE: sv/gpioc_merge.sv
// gathers the lane results into one result transaction and holds it in the output register
module gpioc_merge import gpioc_pkg::*; #(
  parameter int unsigned LANES = PIN_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [LANES-1:0] rd_i,
  input  logic [LANES-1:0] irq_i,
  input  logic [LANES-1:0] level_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output out_t             out_o,
  output logic             busy_o
);

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  always_comb begin
    out_d = '0;
    out_d.read_data[LANES-1:0]  = rd_i;
    out_d.irq_pins[LANES-1:0]   = irq_i;
    out_d.pin_levels[LANES-1:0] = level_i;
  end

  assign busy_o      = out_valid_q & out_stall_i;
  assign out_valid_d = fire_i | busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sv/gpio_controller_with_pin_interrupts_unit.sv
// top level of the gpio controller with per-pin interrupt detection
//
// Input channel in_valid_i / in_stall_o carries one transaction per item: a bus
// read, a bus write to a word register, or an external pin update under a mask.
// Output channel out_valid_o / out_stall_i returns exactly one result per item:
// read data, the pins whose interrupt condition fired, and the pin levels after.
// Each pin is its own lane holding that pin's register bits; the merge stage
// packs the lane bits into the output register.
// out_valid_o rises in the cycle after acceptance. Throughput is one item
// per cycle, set by the single output register: a new item is taken whenever
// the output register is empty or its result is taken in the same cycle.
// When the receiver stalls, the result holds and in_stall_o rises until the
// result is taken. Reset clears all registers, pin levels and pending bits and
// empties the output register. Pins at index PIN_COUNT and up read 0 and are ignored.
module gpio_controller_with_pin_interrupts_unit import gpioc_pkg::*; #(
  parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned LANES = (PIN_COUNT < DATA_W) ? PIN_COUNT : DATA_W;

  ctl_t             ctl;
  logic             busy;
  logic [LANES-1:0] lane_rd, lane_irq, lane_level;

  assign in_stall_o = busy;

  always_comb begin
    ctl.fire = in_valid_i & ~busy;
    ctl.rd   = (in_i.action == ACT_READ);
    ctl.wr   = (in_i.action == ACT_WRITE);
    ctl.pins = (in_i.action == ACT_PINS);
    ctl.word = in_i.reg_word;
    ctl.eval = ctl.pins | (ctl.wr && (in_i.reg_word inside {WORD_IN_ENABLE, WORD_OUT_ENABLE,
               WORD_OUT_LEVEL, WORD_RISE_ENABLE, WORD_FALL_ENABLE, WORD_HIGH_ENABLE,
               WORD_LOW_ENABLE, WORD_OUT_INVERT}));
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gpioc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .data_i  (in_i.write_data[i]),
      .set_i   (in_i.pin_set[i]),
      .mask_i  (in_i.pin_mask[i]),
      .rd_o    (lane_rd[i]),
      .irq_o   (lane_irq[i]),
      .level_o (lane_level[i])
    );
  end

  gpioc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (ctl.fire),
    .rd_i        (lane_rd),
    .irq_i       (lane_irq),
    .level_i     (lane_level),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .busy_o      (busy)
  );

`ifndef NO_ASSERTIONS
  a_read_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fire && ctl.rd |=> out_valid_o && out_o.irq_pins == '0)
    else $error("read transaction reported interrupts");

  a_noeval_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.eval |-> lane_irq == '0)
    else $error("interrupt without pin evaluation");

  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fire && !ctl.rd |=> out_o.read_data == '0)
    else $error("read data on a non-read transaction");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");
`endif

endmodule
